[sv/mted_pkg.sv]
// Package for the multitap echo delay: controller states, command and status structs,
// configuration register indexes and fixed-point constants. No dependencies.

package mted_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_OUT
    } mted_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic read;
        logic mul;
        logic acc;
        logic emit;
    } mted_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } mted_stat_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_DRY_CUT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK   = 3'd3;

    localparam int ECHO_W  = 4;
    localparam int DELAY_W = 16;
    localparam int FB_W    = 7;

    localparam logic [ECHO_W-1:0]  ECHO_RESET  = 4'd1;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd48000;
    localparam logic [FB_W-1:0]    FB_RESET    = 7'd50;
    localparam logic [FB_W-1:0]    FB_FULL     = 7'd100;

    // gains are unsigned Q1.16, unity = 65536
    localparam int GAIN_W    = 17;
    localparam int FRAC_BITS = 16;
    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

    // g * fb + 50 before the divide by 100
    localparam int GPROD_W = 23;
    localparam logic [GAIN_W+FB_W-1:0] FB_ROUND = 24'd50;

    // x / 100 == (x * ceil(2^30 / 100)) >> 30, exact for x < 2^23
    localparam int DIV100_W     = 24;
    localparam int DIV100_SHIFT = 30;
    localparam logic [DIV100_W-1:0] DIV100_MAGIC = 24'd10737419;

    localparam int ROUND_HALF = 32768;

endpackage

[sv/multitap_echo_delay.sv]
// Top level of the multitap echo delay: configuration registers and their clamps,
// controller and datapath. Depends on mted_pkg, mted_ctrl and mted_datapath.
//
//   channel   direction  handshake              payload
//   in        sink       in_valid / in_ready    sample_in
//   out       source     out_valid / out_ready  sample_out
//   cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Items are accepted one at a time: in_ready is high only in the idle state and
// returns once the result is taken into the output register. With n the clamped
// echo count, each item takes n taps; each tap is a memory read, a multiply and an
// accumulate on the single ring port and the shared tap multiplier.
// Reset leaves the ring uncleared; a wrap flag makes unwritten slots read as zero.
// A result waiting in the output register holds the block in its final state.
// cfg_ready is always high.

module multitap_echo_delay #(
    parameter int MAX_ECHOES  = 8,
    parameter int MAX_DELAY   = 65536,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [SAMPLE_BITS-1:0]         sample_in,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [SAMPLE_BITS-1:0]         sample_out,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mted_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mted_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int TAP_W = $clog2(MAX_ECHOES + 1);
    localparam int DLY_W = $clog2(MAX_DELAY + 1);

    logic                              dry_cut_reg;
    logic [mted_pkg::ECHO_W-1:0]       echo_count_reg;
    logic [mted_pkg::DELAY_W-1:0]      delay_samples_reg;
    logic [mted_pkg::FB_W-1:0]         feedback_reg;

    logic [TAP_W-1:0]                  taps;
    logic [DLY_W-1:0]                  dly;
    logic [mted_pkg::FB_W-1:0]         fb;

    mted_pkg::mted_cmd_t               cmd;
    mted_pkg::mted_stat_t              stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dry_cut_reg       <= 1'b0;
            echo_count_reg    <= mted_pkg::ECHO_RESET;
            delay_samples_reg <= mted_pkg::DELAY_RESET;
            feedback_reg      <= mted_pkg::FB_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                mted_pkg::CFG_DRY_CUT:    dry_cut_reg       <= cfg_data[0];
                mted_pkg::CFG_ECHO_COUNT: echo_count_reg    <= cfg_data[mted_pkg::ECHO_W-1:0];
                mted_pkg::CFG_DELAY:      delay_samples_reg <= cfg_data[mted_pkg::DELAY_W-1:0];
                mted_pkg::CFG_FEEDBACK:   feedback_reg      <= cfg_data[mted_pkg::FB_W-1:0];
                default:                  dry_cut_reg       <= dry_cut_reg;
            endcase
        end
    end

    always_comb
    begin
        if (32'(echo_count_reg) > MAX_ECHOES)
        begin
            taps = TAP_W'(MAX_ECHOES);
        end
        else
        begin
            taps = TAP_W'(echo_count_reg);
        end
        if (32'(delay_samples_reg) > MAX_DELAY)
        begin
            dly = DLY_W'(MAX_DELAY);
        end
        else
        begin
            dly = DLY_W'(delay_samples_reg);
        end
        fb = (feedback_reg > mted_pkg::FB_FULL) ? mted_pkg::FB_FULL : feedback_reg;
    end

    mted_ctrl #(
        .MAX_ECHOES (MAX_ECHOES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .taps     (taps),
        .stat     (stat),
        .cmd      (cmd)
    );

    mted_datapath #(
        .MAX_ECHOES  (MAX_ECHOES),
        .MAX_DELAY   (MAX_DELAY),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .sample_in  (sample_in),
        .dry_cut    (dry_cut_reg),
        .dly        (dly),
        .fb         (fb),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .sample_out (sample_out)
    );

`ifndef SYNTHESIS
    // one item in flight: no second acceptance right after the first
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an item is in flight");

    // a result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid || out_ready))
        else $error("result register overwritten");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid)
        else $error("result not presented after emit");

    a_tap_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read |=> cmd.mul ##1 cmd.acc)
        else $error("tap sequence broken");
`endif

endmodule

[sv/mted_ctrl.sv]
// Controller for the multitap echo delay: sequences load, per-tap read, multiply and
// accumulate, then hands the result over. Depends on mted_pkg.

module mted_ctrl #(
    parameter int MAX_ECHOES = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [$clog2(MAX_ECHOES+1)-1:0]     taps,
    input  mted_pkg::mted_stat_t                stat,
    output mted_pkg::mted_cmd_t                 cmd
);

    localparam int TAP_W = $clog2(MAX_ECHOES + 1);

    mted_pkg::mted_state_t state_reg;
    mted_pkg::mted_state_t state_next;
    logic [TAP_W-1:0]      cnt_reg;
    logic [TAP_W-1:0]      cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mted_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mted_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (taps == '0) ? mted_pkg::ST_OUT : mted_pkg::ST_READ;
                end
            end
            mted_pkg::ST_READ:
            begin
                state_next = mted_pkg::ST_MUL;
            end
            mted_pkg::ST_MUL:
            begin
                state_next = mted_pkg::ST_ACC;
            end
            mted_pkg::ST_ACC:
            begin
                state_next = (cnt_reg == taps) ? mted_pkg::ST_OUT : mted_pkg::ST_READ;
            end
            mted_pkg::ST_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = mted_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mted_pkg::ST_IDLE;
            end
        endcase
    end

    // index of the tap in progress, counting from one
    always_comb
    begin
        cnt_next = cnt_reg;
        if (state_reg == mted_pkg::ST_IDLE && in_valid)
        begin
            cnt_next = TAP_W'(1);
        end
        else if (state_reg == mted_pkg::ST_ACC && cnt_reg != taps)
        begin
            cnt_next = cnt_reg + TAP_W'(1);
        end
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            mted_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            mted_pkg::ST_READ:
            begin
                cmd.read = 1'b1;
            end
            mted_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            mted_pkg::ST_ACC:
            begin
                cmd.acc = 1'b1;
            end
            mted_pkg::ST_OUT:
            begin
                cmd.emit = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

[sv/mted_datapath.sv]
// Datapath for the multitap echo delay: sample ring memory, tap address and gain
// recurrences, tap multiplier, accumulator and output register. Depends on mted_pkg.

module mted_datapath #(
    parameter int MAX_ECHOES  = 8,
    parameter int MAX_DELAY   = 65536,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mted_pkg::mted_cmd_t                 cmd,
    output mted_pkg::mted_stat_t                stat,
    input  logic signed [SAMPLE_BITS-1:0]       sample_in,
    input  logic                                dry_cut,
    input  logic [$clog2(MAX_DELAY+1)-1:0]      dly,
    input  logic [mted_pkg::FB_W-1:0]           fb,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic signed [SAMPLE_BITS-1:0]       sample_out
);

    localparam int RING    = MAX_ECHOES * MAX_DELAY;
    localparam int AW      = $clog2(RING);
    localparam int SB      = SAMPLE_BITS;
    localparam int GW      = mted_pkg::GAIN_W;
    localparam int PROD_W  = SB + GW + 1;
    localparam int ACC_W   = SB + 22;
    localparam int RND_W   = ACC_W - mted_pkg::FRAC_BITS;
    localparam int GM_W    = GW + mted_pkg::FB_W;
    localparam int QM_W    = mted_pkg::GPROD_W + mted_pkg::DIV100_W;

    localparam logic [AW:0]   RING_X = (AW + 1)'(RING);
    localparam logic [AW-1:0] W_LAST = AW'(RING - 1);
    localparam logic signed [RND_W-1:0] SAT_HI =
        signed'({{(RND_W - SB + 1){1'b0}}, {(SB - 1){1'b1}}});
    localparam logic signed [RND_W-1:0] SAT_LO = ~SAT_HI;

    logic [SB-1:0] ring_mem [RING];

    logic [AW-1:0]                     w_reg;
    logic                              wrapped_reg;
    logic                              out_valid_reg;
    logic [AW-1:0]                     r_reg;
    logic [mted_pkg::GPROD_W-1:0]      gprod_reg;
    logic [GW-1:0]                     g_reg;
    logic [SB-1:0]                     rdata_reg;
    logic                              hit_reg;
    logic signed [PROD_W-1:0]          prod_reg;
    logic signed [ACC_W-1:0]           acc_reg;
    logic signed [SB-1:0]              out_reg;

    logic [AW:0]                       base_x;
    logic [AW:0]                       dly_x;
    logic [AW:0]                       r_next;
    logic [GW-1:0]                     g_sel;
    logic [GM_W-1:0]                   gm;
    logic [mted_pkg::GPROD_W-1:0]      gprod_next;
    logic [QM_W-1:0]                   qm;
    logic [GW-1:0]                     g_next;
    logic signed [SB-1:0]              tap_val;
    logic signed [GW:0]                g_s;
    logic signed [PROD_W-1:0]          prod_next;
    logic signed [ACC_W-1:0]           acc_init;
    logic signed [ACC_W-1:0]           acc_rnd;
    logic signed [RND_W-1:0]           rnd;
    logic signed [SB-1:0]              sat_next;

    // tap address walks back by dly each step, modulo the ring
    always_comb
    begin
        base_x = (AW + 1)'(cmd.load ? w_reg : r_reg);
        dly_x  = (AW + 1)'(dly);
        if (base_x >= dly_x)
        begin
            r_next = base_x - dly_x;
        end
        else
        begin
            r_next = base_x + RING_X - dly_x;
        end
    end

    // gain recurrence g' = (g * fb + 50) / 100
    always_comb
    begin
        g_sel      = cmd.load ? mted_pkg::GAIN_ONE : g_reg;
        gm         = GM_W'(g_sel) * GM_W'(fb);
        gprod_next = mted_pkg::GPROD_W'(gm + mted_pkg::FB_ROUND);
        qm         = QM_W'(gprod_reg) * QM_W'(mted_pkg::DIV100_MAGIC);
        g_next     = qm[mted_pkg::DIV100_SHIFT +: GW];
    end

    always_comb
    begin
        tap_val   = hit_reg ? signed'(rdata_reg) : '0;
        g_s       = signed'({1'b0, g_reg});
        prod_next = PROD_W'(tap_val * g_s);
        acc_init  = dry_cut ? '0
                  : {{(ACC_W - mted_pkg::FRAC_BITS - SB){sample_in[SB-1]}}, sample_in,
                     {mted_pkg::FRAC_BITS{1'b0}}};
    end

    always_comb
    begin
        acc_rnd = acc_reg + ACC_W'(mted_pkg::ROUND_HALF);
        rnd     = acc_rnd[ACC_W-1:mted_pkg::FRAC_BITS];
        if (rnd > SAT_HI)
        begin
            sat_next = SAT_HI[SB-1:0];
        end
        else if (rnd < SAT_LO)
        begin
            sat_next = SAT_LO[SB-1:0];
        end
        else
        begin
            sat_next = rnd[SB-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ring_mem[w_reg] <= sample_in;
        end
        if (cmd.read)
        begin
            rdata_reg <= ring_mem[r_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load || cmd.acc)
        begin
            r_reg     <= r_next[AW-1:0];
            gprod_reg <= gprod_next;
        end
        if (cmd.load)
        begin
            acc_reg <= acc_init;
        end
        else if (cmd.acc)
        begin
            acc_reg <= acc_reg + {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
        if (cmd.read)
        begin
            g_reg   <= g_next;
            // slots not yet written since reset read as silence
            hit_reg <= wrapped_reg || (r_reg <= w_reg);
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.emit)
        begin
            out_reg <= sat_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg         <= '0;
            wrapped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                if (w_reg == W_LAST)
                begin
                    w_reg       <= '0;
                    wrapped_reg <= 1'b1;
                end
                else
                begin
                    w_reg <= w_reg + AW'(1);
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign sample_out    = out_reg;

endmodule

[verif/tb_multitap_echo_delay.sv]
// Testbench for multitap_echo_delay: a directed table, then random items under three idling
// patterns, each result checked against the table's typed value or an in-bench echo
// predictor. Depends on mted_pkg and the multitap_echo_delay RTL.

module tb_multitap_echo_delay;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SMP_W         = 24;
    localparam int ECHO_LIMIT    = 8;
    localparam int RING_W        = 19;
    localparam int RING_DEPTH    = 1 << RING_W;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 160;
    localparam int DIRECTED_ROWS = 48;

    localparam logic [mted_pkg::CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd4;
    localparam logic [mted_pkg::CFG_IDX_W-1:0] REG_UNUSED_LAST  = 3'd7;

    localparam logic signed [SMP_W-1:0] SMP_MAX = 24'sh7FFFFF;
    localparam logic signed [SMP_W-1:0] SMP_MIN = 24'sh800000;

    typedef struct packed {
        logic                                is_cfg;
        logic [mted_pkg::CFG_IDX_W-1:0]      idx;
        logic [mted_pkg::CFG_DATA_W-1:0]     data;
        logic signed [SMP_W-1:0]             smp;
        logic                                typed;
        logic signed [SMP_W-1:0]             typed_val;
    } stim_row_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic signed [SMP_W-1:0]             sample_in = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic signed [SMP_W-1:0]             sample_out;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [mted_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [mted_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

    // predictor state
    int                                  echo_hist [RING_DEPTH];
    logic [RING_W-1:0]                   hist_wr = '0;
    logic                                cur_dry = 1'b0;
    logic [mted_pkg::ECHO_W-1:0]         cur_echo = mted_pkg::ECHO_RESET;
    logic [mted_pkg::DELAY_W-1:0]        cur_delay = mted_pkg::DELAY_RESET;
    logic [mted_pkg::FB_W-1:0]           cur_fb = mted_pkg::FB_RESET;

    logic signed [SMP_W-1:0]             expected_samples [$];
    int                                  mismatch_count = 0;
    int                                  cycle_count = 0;
    int                                  send_idle_pct = 20;
    int                                  recv_stall_pct = 53;

    stim_row_t directed [DIRECTED_ROWS] = '{
        '{1'b0, 3'd0, 16'h0000, SMP_MAX, 1'b1, SMP_MAX},
        '{1'b0, 3'd0, 16'h0000, SMP_MIN, 1'b1, SMP_MIN},
        '{1'b1, mted_pkg::CFG_DRY_CUT, 16'hFFFF, 24'sd0, 1'b0, 24'sd0},
        '{1'b0, 3'd0, 16'h0000, 24'sd12345, 1'b1, 24'sd0},
        '{1'b1, mted_pkg::CFG_DELAY, 16'h0000, 24'sd0, 1'b0, 24'sd0},
        '{1'b1, mted_pkg::CFG_FEEDBACK, 16'd100, 24'sd0, 1'b0, 24'sd0},
        '{1'b0, 3'd0, 16'h0000, -24'sd77, 1'b1, -24'sd77},
        '{1'b1, mted_pkg::CFG_FEEDBACK, 16'd50, 24'sd0, 1'b0, 24'sd0},
        '{1'b0, 3'd0, 16'h0000, 24'sd1, 1'b1, 24'sd1},
        '{1'b0, 3'd0, 16'h0000, -24'sd1, 1'b1, 24'sd0},
        '{1'b1, mted_pkg::CFG_DRY_CUT, 16'h0000, 24'sd0, 1'b0, 24'sd0},
        '{1'b1, mted_pkg::CFG_ECHO_COUNT, 16'd8, 24'sd0, 1'b0, 24'sd0},
        '{1'b1, mted_pkg::CFG_FEEDBACK, 16'd100, 24'sd0, 1'b0, 24'sd0},
        '{1'b0, 3'd0, 16'h0000, SMP_MAX, 1'b1, SMP_MAX},
        '{1'b0, 3'd0, 16'h0000, SMP_MIN, 1'b1, SMP_MIN},
        '{1'b0, 3'd0, 16'h0000, 24'sd1, 1'b1, 24'sd9},
        '{1'b1, mted_pkg::CFG_ECHO_COUNT, 16'd15, 24'sd0, 1'b0, 24'sd0},
        '{1'b0, 3'd0, 16'h0000, 24'sd2, 1'b1, 24'sd18},
        '{1'b1, mted_pkg::CFG_FEEDBACK, 16'hFFFF, 24'sd0, 1'b0, 24'sd0},
        '{1'b0, 3'd0, 16'h0000, 24'sd3, 1'b1, 24'sd27},
        '{1'b1, mted_pkg::CFG_FEEDBACK, 16'h0000, 24'sd0, 1'b0, 24'sd0},
        '{1'b0, 3'd0, 16'h0000, 24'sd1000, 1'b1, 24'sd1000},
        '{1'b1, REG_UNUSED_FIRST, 16'h0000, 24'sd0, 1'b0, 24'sd0},
        '{1'b1, REG_UNUSED_LAST, 16'hFFFF, 24'sd0, 1'b0, 24'sd0},
        '{1'b0, 3'd0, 16'h0000, 24'sd4, 1'b1, 24'sd4},
        '{1'b1, mted_pkg::CFG_ECHO_COUNT, 16'h0000, 24'sd0, 1'b0, 24'sd0},
        '{1'b0, 3'd0, 16'h0000, -24'sd5, 1'b1, -24'sd5},
        '{1'b1, mted_pkg::CFG_ECHO_COUNT, 16'hFFF8, 24'sd0, 1'b0, 24'sd0},
        '{1'b1, mted_pkg::CFG_FEEDBACK, 16'd100, 24'sd0, 1'b0, 24'sd0},
        '{1'b1, mted_pkg::CFG_DELAY, 16'hFFFF, 24'sd0, 1'b0, 24'sd0},
        '{1'b0, 3'd0, 16'h0000, 24'sd100, 1'b1, 24'sd100},
        '{1'b1, mted_pkg::CFG_DELAY, 16'd1, 24'sd0, 1'b0, 24'sd0},
        '{1'b1, mted_pkg::CFG_FEEDBACK, 16'd50, 24'sd0, 1'b0, 24'sd0},
        '{1'b1, mted_pkg::CFG_ECHO_COUNT, 16'd3, 24'sd0, 1'b0, 24'sd0},
        '{1'b0, 3'd0, 16'h0000, 24'sd4000000, 1'b0, 24'sd0},
        '{1'b0, 3'd0, 16'h0000, -24'sd3000000, 1'b0, 24'sd0},
        '{1'b0, 3'd0, 16'h0000, SMP_MAX, 1'b0, 24'sd0},
        '{1'b0, 3'd0, 16'h0000, SMP_MIN, 1'b0, 24'sd0},
        '{1'b0, 3'd0, 16'h0000, 24'sd123456, 1'b0, 24'sd0},
        '{1'b1, mted_pkg::CFG_DELAY, 16'd3, 24'sd0, 1'b0, 24'sd0},
        '{1'b1, mted_pkg::CFG_ECHO_COUNT, 16'd8, 24'sd0, 1'b0, 24'sd0},
        '{1'b1, mted_pkg::CFG_FEEDBACK, 16'd99, 24'sd0, 1'b0, 24'sd0},
        '{1'b0, 3'd0, 16'h0000, SMP_MIN, 1'b0, 24'sd0},
        '{1'b0, 3'd0, 16'h0000, SMP_MAX, 1'b0, 24'sd0},
        '{1'b0, 3'd0, 16'h0000, 24'sd7, 1'b0, 24'sd0},
        '{1'b0, 3'd0, 16'h0000, SMP_MAX, 1'b0, 24'sd0},
        '{1'b1, REG_UNUSED_FIRST, 16'h5A5A, 24'sd0, 1'b0, 24'sd0},
        '{1'b0, 3'd0, 16'h0000, -24'sd8, 1'b0, 24'sd0}
    };

    multitap_echo_delay dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // write the new item, then sum the taps, round half up once and saturate
    function automatic logic signed [SMP_W-1:0] echo_mix(input logic signed [SMP_W-1:0] smp);
        int                taps;
        longint            fb;
        longint            gain;
        longint            acc;
        longint            rounded;
        logic [RING_W-1:0] slot;
        begin
            echo_hist[hist_wr] = smp;
            taps = (cur_echo > ECHO_LIMIT) ? ECHO_LIMIT : int'(cur_echo);
            fb = (cur_fb > mted_pkg::FB_FULL) ? longint'(mted_pkg::FB_FULL) : longint'(cur_fb);
            acc = cur_dry ? 64'sd0 : longint'(smp) * longint'(mted_pkg::GAIN_ONE);
            gain = longint'(mted_pkg::GAIN_ONE);
            // 16-bit delay never exceeds the ring span per tap, so no clamp needed
            for (int k = 1; k <= taps; k++)
            begin
                slot = hist_wr - RING_W'(k * int'(cur_delay));
                gain = (gain * fb + 50) / 100;
                acc += longint'(echo_hist[slot]) * gain;
            end
            hist_wr = hist_wr + 1'b1;
            rounded = (acc + mted_pkg::ROUND_HALF) >>> mted_pkg::FRAC_BITS;
            if (rounded > longint'(SMP_MAX))
                return SMP_MAX;
            if (rounded < longint'(SMP_MIN))
                return SMP_MIN;
            return SMP_W'(rounded);
        end
    endfunction

    function automatic void apply_reg(input logic [mted_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [mted_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            mted_pkg::CFG_DRY_CUT:    cur_dry = data[0];
            mted_pkg::CFG_ECHO_COUNT: cur_echo = data[mted_pkg::ECHO_W-1:0];
            mted_pkg::CFG_DELAY:      cur_delay = data[mted_pkg::DELAY_W-1:0];
            mted_pkg::CFG_FEEDBACK:   cur_fb = data[mted_pkg::FB_W-1:0];
            default:                  ;
        endcase
    endfunction

    function automatic logic signed [SMP_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2, 3, 4: return SMP_W'($urandom);
            default: return SMP_W'(int'($urandom_range(0, 8191)) - 4096);
        endcase
    endfunction

    // registers change only once every result is out
    task automatic write_reg(input logic [mted_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mted_pkg::CFG_DATA_W-1:0] data);
        in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, data);
    endtask

    task automatic send_sample(input logic signed [SMP_W-1:0] smp, input logic typed,
                               input logic signed [SMP_W-1:0] typed_val);
        logic signed [SMP_W-1:0] mixed;
        cfg_valid <= 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_in <= smp;
        do @(posedge clk); while (!in_ready);
        mixed = echo_mix(smp);
        expected_samples.push_back(typed ? typed_val : mixed);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
        do @(posedge clk); while (expected_samples.size() != 0);
    endtask

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin : out_check
        logic signed [SMP_W-1:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_samples.size() == 0)
            begin
                $error("sample_out: expected none, actual %0d", sample_out);
                mismatch_count++;
            end
            else
            begin
                want = expected_samples.pop_front();
                if (sample_out !== want)
                begin
                    $error("sample_out: expected %0d, actual %0d", want, sample_out);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic                            dry_v;
        logic [mted_pkg::ECHO_W-1:0]     echo_v;
        logic [mted_pkg::DELAY_W-1:0]    delay_v;
        logic [mted_pkg::FB_W-1:0]       fb_v;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (directed[r].is_cfg)
                write_reg(directed[r].idx, directed[r].data);
            else
                send_sample(directed[r].smp, directed[r].typed, directed[r].typed_val);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            send_idle_pct = (phase < 4) ? 20 : (phase < 8) ? 53 : 0;
            recv_stall_pct = (phase < 4) ? 53 : (phase < 8) ? 20 : 0;
            case (phase % 4)
                0:
                begin
                    dry_v = 1'b0;
                    echo_v = 4'd8;
                    fb_v = mted_pkg::FB_FULL;
                    delay_v = mted_pkg::DELAY_W'($urandom_range(1, 40));
                end
                1:
                begin
                    dry_v = 1'($urandom);
                    echo_v = mted_pkg::ECHO_W'($urandom_range(9, 15));
                    fb_v = mted_pkg::FB_W'($urandom_range(101, 127));
                    delay_v = (phase == 1) ? 16'h0000 : 16'hFFFF;
                end
                2:
                begin
                    dry_v = 1'b1;
                    echo_v = mted_pkg::ECHO_W'($urandom_range(1, 8));
                    fb_v = mted_pkg::FB_W'($urandom_range(0, 100));
                    delay_v = mted_pkg::DELAY_W'($urandom_range(0, 255));
                end
                default:
                begin
                    dry_v = 1'($urandom);
                    echo_v = mted_pkg::ECHO_W'($urandom);
                    fb_v = mted_pkg::FB_W'($urandom);
                    delay_v = ($urandom_range(0, 3) == 0)
                            ? mted_pkg::DELAY_W'($urandom)
                            : mted_pkg::DELAY_W'($urandom_range(0, 255));
                end
            endcase
            // junk above each field's width must be ignored
            write_reg(mted_pkg::CFG_DRY_CUT, {15'($urandom), dry_v});
            write_reg(mted_pkg::CFG_ECHO_COUNT, {12'($urandom), echo_v});
            write_reg(mted_pkg::CFG_DELAY, delay_v);
            write_reg(mted_pkg::CFG_FEEDBACK, {9'($urandom), fb_v});
            write_reg(mted_pkg::CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                      mted_pkg::CFG_DATA_W'($urandom));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 59) == 0)
                    hold_until_drained();
                send_sample(random_sample(), 1'b0, '0);
            end
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
